[rtl/core/i2cst_pkg.sv]
// Package for the I2C SCL timing search block.
// Holds field widths, datapath op codes, divide selects, status codes and the
// command/status structs shared by the controller and the datapath.
package i2cst_pkg;

    localparam int KP_W     = 10;
    localparam int TGT_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int T_W      = 12;
    localparam int Q_W      = 15;
    localparam int PER_W    = 23;
    localparam int SYNC_W   = 17;

    localparam logic [12:0] SCL_LOW_MIN_NS  = 13'd4700;
    localparam logic [12:0] SCL_HIGH_MIN_NS = 13'd4000;
    localparam logic [7:0]  COUNT_MAX       = 8'd255;
    localparam logic [3:0]  DELAY_MAX       = 4'd15;

    // configuration register indexes
    localparam logic [2:0] CFG_RISE  = 3'd0;
    localparam logic [2:0] CFG_FALL  = 3'd1;
    localparam logic [2:0] CFG_DVMAX = 3'd2;
    localparam logic [2:0] CFG_SETUP = 3'd3;
    localparam logic [2:0] CFG_HOLD  = 3'd4;
    localparam logic [2:0] CFG_AFMIN = 3'd5;
    localparam logic [2:0] CFG_AFMAX = 3'd6;
    localparam logic [2:0] CFG_DNF   = 3'd7;

    // datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_SETUP = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_INIT  = 3'd4;
    localparam logic [2:0] OP_STEP  = 3'd5;
    localparam logic [2:0] OP_NEXTP = 3'd6;
    localparam logic [2:0] OP_FIN   = 3'd7;

    // divide selects
    localparam logic [2:0] SEL_LO   = 3'd0;
    localparam logic [2:0] SEL_HI   = 3'd1;
    localparam logic [2:0] SEL_SMIN = 3'd2;
    localparam logic [2:0] SEL_SMAX = 3'd3;
    localparam logic [2:0] SEL_CMIN = 3'd4;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOACH = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] sel;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic kp_zero;
        logic cnt_big;
        logic too_long;
        logic per_short;
        logic both_full;
        logic smax_neg;
        logic delay_fail;
        logic p_zero;
    } t_stat;

endpackage

[rtl/core/i2cst_in_if.sv]
// Request channel of the I2C SCL timing search block.
// Carries valid, ready and the request payload; uses i2cst_pkg widths.
interface i2cst_in_if;
    logic                       valid;
    logic                       ready;
    logic [i2cst_pkg::KP_W-1:0]  kernel_period_ns;
    logic [i2cst_pkg::TGT_W-1:0] target_scl_period_ns;

    modport source (output valid, kernel_period_ns, target_scl_period_ns, input ready);
    modport sink   (input valid, kernel_period_ns, target_scl_period_ns, output ready);
endinterface

[rtl/core/i2cst_out_if.sv]
// Result channel of the I2C SCL timing search block.
// Carries valid, ready and the result payload; no package dependency.
interface i2cst_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] prescale;
    logic [7:0] low_count;
    logic [7:0] high_count;
    logic [3:0] sda_delay;
    logic [3:0] scl_delay;

    modport source (output valid, status, prescale, low_count, high_count, sda_delay,
                    scl_delay, input ready);
    modport sink   (input valid, status, prescale, low_count, high_count, sda_delay,
                    scl_delay, output ready);
endinterface

[rtl/core/i2cst_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on i2cst_pkg for operand widths.
module i2cst_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [i2cst_pkg::Q_W-1:0]   i_dividend,
    input  logic [i2cst_pkg::T_W-1:0]   i_divisor,
    output logic [i2cst_pkg::Q_W-1:0]   o_quotient,
    output logic                        o_done
);
    import i2cst_pkg::*;

    logic [T_W-1:0] r_rem;
    logic [Q_W-1:0] r_quo;
    logic [T_W-1:0] r_dvs;
    logic [3:0]     r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [T_W:0]   shifted;
    logic [T_W:0]   trial;
    logic           fits;

    // trial subtract of the shifted remainder
    always_comb begin
        shifted = {r_rem, r_quo[Q_W-1]};
        trial   = shifted - {1'b0, r_dvs};
        fits    = shifted >= {1'b0, r_dvs};
    end

    // control: run Q_W steps after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift in one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? trial[T_W-1:0] : shifted[T_W-1:0];
            r_quo <= {r_quo[Q_W-2:0], fits};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;
endmodule

[rtl/core/i2cst_datapath.sv]
// Datapath of the I2C SCL timing search: configuration registers, count and
// period registers, delay bounds and result registers. Uses i2cst_pkg, i2cst_div.
module i2cst_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [i2cst_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [i2cst_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic [i2cst_pkg::KP_W-1:0]      i_kp,
    input  logic [i2cst_pkg::TGT_W-1:0]     i_target,
    input  i2cst_pkg::t_cmd                 i_cmd,
    output i2cst_pkg::t_stat                o_stat,
    output logic [1:0]                      o_status,
    output logic [1:0]                      o_prescale,
    output logic [7:0]                      o_low_count,
    output logic [7:0]                      o_high_count,
    output logic [3:0]                      o_sda_delay,
    output logic [3:0]                      o_scl_delay
);
    import i2cst_pkg::*;

    // configuration
    logic [11:0] r_rise, r_fall, r_setup, r_hold;
    logic [12:0] r_dvmax;
    logic [9:0]  r_afmin, r_afmax;
    logic [3:0]  r_dnf;

    // work registers
    logic [KP_W-1:0]   r_kp;
    logic [TGT_W-1:0]  r_target;
    logic [1:0]        r_p;
    logic [T_W-1:0]    r_t;
    logic [SYNC_W-1:0] r_sync;
    logic [Q_W-1:0]    r_lo, r_hi, r_smin, r_smax, r_cmin;
    logic [PER_W-1:0]  r_per;
    logic              r_raise, r_lo_full, r_hi_full;

    // result registers
    logic [1:0] r_o_status, r_o_prescale;
    logic [7:0] r_o_low, r_o_high;
    logic [3:0] r_o_sda, r_o_scl;

    logic [14:0]        fall6, rise6;
    logic [30:0]        fall_prod, rise_prod;
    logic [14:0]        dnf3kp, dnf4kp;
    logic [SYNC_W-1:0]  n_sync;
    logic signed [16:0] num_smin, num_smax;
    logic [Q_W-1:0]     dividend;
    logic [Q_W-1:0]     quotient;
    logic               div_done;
    logic [3:0]         smax_cap;
    logic [Q_W-1:0]     cmin_adj;
    logic [7:0]         sda_sum, scl_sum;
    logic [15:0]        sda_prod, scl_prod;
    logic [9:0]         cnt_sum;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise  <= 12'd1000;
            r_fall  <= 12'd300;
            r_dvmax <= 13'd3450;
            r_setup <= 12'd250;
            r_hold  <= 12'd0;
            r_afmin <= 10'd50;
            r_afmax <= 10'd260;
            r_dnf   <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RISE:  r_rise  <= i_cfg_data[11:0];
                CFG_FALL:  r_fall  <= i_cfg_data[11:0];
                CFG_DVMAX: r_dvmax <= i_cfg_data;
                CFG_SETUP: r_setup <= i_cfg_data[11:0];
                CFG_HOLD:  r_hold  <= i_cfg_data[11:0];
                CFG_AFMIN: r_afmin <= i_cfg_data[9:0];
                CFG_AFMAX: r_afmax <= i_cfg_data[9:0];
                CFG_DNF:   r_dnf   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // sync delays: x*6/10 by reciprocal multiply, exact for x below 43690
    always_comb begin
        fall6     = {3'b0, r_fall} * 15'd6;
        rise6     = {3'b0, r_rise} * 15'd6;
        fall_prod = {16'b0, fall6} * 31'd52429;
        rise_prod = {16'b0, rise6} * 31'd52429;
        dnf3kp    = ({11'b0, r_dnf} + 15'd3) * {5'b0, r_kp};
        dnf4kp    = ({11'b0, r_dnf} + 15'd4) * {5'b0, r_kp};
        n_sync    = SYNC_W'(fall_prod[30:19]) + SYNC_W'(rise_prod[30:19])
                  + SYNC_W'({r_afmax, 1'b0}) + SYNC_W'({dnf3kp, 1'b0});
    end

    // delay bound numerators
    always_comb begin
        num_smin = $signed({5'b0, r_fall}) + $signed({5'b0, r_hold})
                 - $signed({7'b0, r_afmin}) + $signed({2'b0, dnf3kp});
        num_smax = $signed({4'b0, r_dvmax}) - $signed({5'b0, r_rise})
                 - $signed({7'b0, r_afmax}) - $signed({2'b0, dnf4kp});
    end

    // pick the dividend for the requested quotient
    always_comb begin
        case (i_cmd.sel)
            SEL_LO:   dividend = Q_W'(SCL_LOW_MIN_NS);
            SEL_HI:   dividend = Q_W'(SCL_HIGH_MIN_NS);
            SEL_SMIN: dividend = (num_smin > 17'sd0) ? num_smin[Q_W-1:0] : '0;
            SEL_SMAX: dividend = num_smax[Q_W-1:0];
            SEL_CMIN: dividend = {2'b0, {1'b0, r_rise} + {1'b0, r_setup}};
            default:  dividend = '0;
        endcase
    end

    i2cst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV),
        .i_dividend (dividend),
        .i_divisor  (r_t),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    assign cnt_sum = {2'b0, r_lo[7:0]} + {2'b0, r_hi[7:0]};

    // search registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_kp     <= i_kp;
                r_target <= i_target;
                r_p      <= 2'd3;
            end
            OP_SETUP: begin
                r_t       <= T_W'({2'b0, r_kp} * ({10'b0, r_p} + 12'd1));
                r_sync    <= n_sync;
                r_raise   <= 1'b1;
                r_lo_full <= 1'b0;
                r_hi_full <= 1'b0;
            end
            OP_INIT: begin
                r_per <= PER_W'(r_sync) + PER_W'({12'b0, cnt_sum} * {10'b0, r_t});
            end
            OP_STEP: begin
                r_raise <= !r_raise;
                if (r_raise) begin
                    if (r_lo[7:0] < COUNT_MAX) begin
                        r_lo  <= r_lo + Q_W'(1);
                        r_per <= r_per + PER_W'(r_t);
                    end else begin
                        r_lo_full <= 1'b1;
                    end
                end else begin
                    if (r_hi[7:0] < COUNT_MAX) begin
                        r_hi  <= r_hi + Q_W'(1);
                        r_per <= r_per + PER_W'(r_t);
                    end else begin
                        r_hi_full <= 1'b1;
                    end
                end
            end
            OP_NEXTP: begin
                r_p <= r_p - 2'd1;
            end
            default: ;
        endcase
        // store quotient when the divider finishes
        if (div_done) begin
            case (i_cmd.sel)
                SEL_LO:   r_lo   <= quotient;
                SEL_HI:   r_hi   <= quotient;
                SEL_SMIN: r_smin <= quotient;
                SEL_SMAX: r_smax <= quotient;
                SEL_CMIN: r_cmin <= quotient;
                default: ;
            endcase
        end
    end

    // delay placement 70/30; x/10 by *205>>11, exact for x below 1029
    always_comb begin
        smax_cap = (r_smax > Q_W'(DELAY_MAX)) ? DELAY_MAX : r_smax[3:0];
        cmin_adj = (r_cmin == '0) ? '0 : r_cmin - Q_W'(1);
        sda_sum  = 8'd7 * {4'b0, r_smin[3:0]} + 8'd3 * {4'b0, smax_cap};
        scl_sum  = 8'd7 * {4'b0, cmin_adj[3:0]} + 8'd45;
        sda_prod = {8'b0, sda_sum} * 16'd205;
        scl_prod = {8'b0, scl_sum} * 16'd205;
    end

    // status flags for the controller
    always_comb begin
        o_stat.div_done   = div_done;
        o_stat.kp_zero    = (r_kp == '0);
        o_stat.cnt_big    = (r_lo > Q_W'(COUNT_MAX)) || (r_hi > Q_W'(COUNT_MAX));
        o_stat.too_long   = r_per > PER_W'(r_target);
        o_stat.per_short  = r_per < PER_W'(r_target);
        o_stat.both_full  = r_lo_full && r_hi_full;
        o_stat.smax_neg   = num_smax < 17'sd0;
        o_stat.delay_fail = (r_smin > Q_W'(smax_cap)) || (cmin_adj > Q_W'(DELAY_MAX));
        o_stat.p_zero     = (r_p == 2'd0);
    end

    // result capture; failures report zero fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FIN) begin
            r_o_status <= i_cmd.status;
            if (i_cmd.status == ST_OK) begin
                r_o_prescale <= r_p;
                r_o_low      <= r_lo[7:0];
                r_o_high     <= r_hi[7:0];
                r_o_sda      <= sda_prod[14:11];
                r_o_scl      <= scl_prod[14:11];
            end else begin
                r_o_prescale <= '0;
                r_o_low      <= '0;
                r_o_high     <= '0;
                r_o_sda      <= '0;
                r_o_scl      <= '0;
            end
        end
    end

    assign o_status     = r_o_status;
    assign o_prescale   = r_o_prescale;
    assign o_low_count  = r_o_low;
    assign o_high_count = r_o_high;
    assign o_sda_delay  = r_o_sda;
    assign o_scl_delay  = r_o_scl;
endmodule

[rtl/core/i2cst_ctrl.sv]
// Controller of the I2C SCL timing search: sequences prescaler attempts,
// divides, the count raise loop and the result handshake. Uses i2cst_pkg.
module i2cst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    input  i2cst_pkg::t_stat i_stat,
    output i2cst_pkg::t_cmd  o_cmd
);
    import i2cst_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK0  = 4'd1;
    localparam logic [3:0] S_SETUP = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_CHKC  = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_LOOP  = 4'd7;
    localparam logic [3:0] S_CHKD  = 4'd8;
    localparam logic [3:0] S_FAIL  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0] r_state, n_state;
    logic [2:0] r_sel, n_sel;
    logic [1:0] r_st, n_st;
    logic       r_rsp_valid;
    logic [2:0] op;
    logic       fin_load;

    // next state and datapath command
    always_comb begin
        n_state  = r_state;
        n_sel    = r_sel;
        n_st     = r_st;
        op       = OP_NONE;
        fin_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    op      = OP_LOAD;
                    n_state = S_CHK0;
                end
            end
            S_CHK0: begin
                if (i_stat.kp_zero) begin
                    n_st    = ST_NOACH;
                    n_state = S_FIN;
                end else begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                op      = OP_SETUP;
                n_sel   = SEL_LO;
                n_state = S_DIV;
            end
            S_DIV: begin
                op      = OP_DIV;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.div_done) begin
                    case (r_sel)
                        SEL_LO: begin
                            n_sel   = SEL_HI;
                            n_state = S_DIV;
                        end
                        SEL_HI: n_state = S_CHKC;
                        SEL_SMIN: begin
                            if (i_stat.smax_neg) begin
                                n_st    = ST_NOACH;
                                n_state = S_FAIL;
                            end else begin
                                n_sel   = SEL_SMAX;
                                n_state = S_DIV;
                            end
                        end
                        SEL_SMAX: begin
                            n_sel   = SEL_CMIN;
                            n_state = S_DIV;
                        end
                        default: n_state = S_CHKD;
                    endcase
                end
            end
            S_CHKC: begin
                if (i_stat.cnt_big) begin
                    n_st    = ST_NOACH;
                    n_state = S_FAIL;
                end else begin
                    op      = OP_INIT;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.too_long) begin
                    n_st    = ST_SHORT;
                    n_state = S_FAIL;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_stat.both_full) begin
                    n_st    = ST_NOACH;
                    n_state = S_FAIL;
                end else if (!i_stat.per_short) begin
                    n_sel   = SEL_SMIN;
                    n_state = S_DIV;
                end else begin
                    op = OP_STEP;
                end
            end
            S_CHKD: begin
                if (i_stat.delay_fail) begin
                    n_st    = ST_NOACH;
                    n_state = S_FAIL;
                end else begin
                    n_st    = ST_OK;
                    n_state = S_FIN;
                end
            end
            S_FAIL: begin
                if (i_stat.p_zero) begin
                    n_state = S_FIN;
                end else begin
                    op      = OP_NEXTP;
                    n_state = S_SETUP;
                end
            end
            S_FIN: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    op       = OP_FIN;
                    fin_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= SEL_LO;
            r_st        <= ST_OK;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_st    <= n_st;
            if (fin_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_rsp_valid  = r_rsp_valid;
    assign o_cmd.op     = op;
    assign o_cmd.sel    = r_sel;
    assign o_cmd.status = r_st;
endmodule

[rtl/core/i2c_scl_timing_search.sv]
// I2C SCL timing search, top level: controller plus datapath with divider.
// For each prescaler tried it runs two divides for the counts and three more
// for the delays, with the count raise loop between them; up to four
// prescalers are tried. One request at a time. Reset (synchronous, active low)
// idles the controller, clears result valid and loads the timing registers'
// defaults.
module i2c_scl_timing_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [i2cst_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [i2cst_pkg::CFG_DAT_W-1:0] i_cfg_data,
    i2cst_in_if.sink                        i_req,
    i2cst_out_if.source                     o_rsp
);
    import i2cst_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    i2cst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    i2cst_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_kp         (i_req.kernel_period_ns),
        .i_target     (i_req.target_scl_period_ns),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_status     (o_rsp.status),
        .o_prescale   (o_rsp.prescale),
        .o_low_count  (o_rsp.low_count),
        .o_high_count (o_rsp.high_count),
        .o_sda_delay  (o_rsp.sda_delay),
        .o_scl_delay  (o_rsp.scl_delay)
    );
endmodule
